// File: rtl/rfwd_pkg.sv
package rfwd_pkg;

	localparam int WORD_W    = 32;
	localparam int FIFO_W    = 5;
	localparam int TYPE_W    = 4;
	localparam int CNT_W     = 13;
	localparam int SPILL_W   = 16;
	localparam int COL_W     = 4;
	localparam int PIX_W     = 4;
	localparam int TDC_W     = 3;
	localparam int ROLL_W    = 26;
	localparam int COARSE_W  = 16;
	localparam int FINE_W    = 10;
	localparam int DEV_W     = 8;
	localparam int ROLLCNT_W = 25;
	localparam int HEAD_W    = 20;

	// packed output bus: 105 payload bits, padded to 14 bytes
	localparam int M_TDATA_W = 112;
	localparam int M_TUSER_W = 5;

	// word prefixes (bits 31:28)
	localparam logic [3:0] TOP_HEADER  = 4'h7;
	localparam logic [3:0] TOP_TRAILER = 4'hF;
	localparam logic [3:0] TOP_TRIGGER = 4'h9;

	localparam logic [WORD_W-1:0] WORD_KILLED   = 32'h666C_AFFE;
	localparam logic [WORD_W-1:0] WORD_ROLLOVER = 32'h5C5C_5C5C;

	localparam logic [TYPE_W-1:0] REC_HIT     = 4'd1;
	localparam logic [TYPE_W-1:0] REC_HEADER  = 4'd7;
	localparam logic [TYPE_W-1:0] REC_TRIGGER = 4'd9;
	localparam logic [TYPE_W-1:0] REC_TRAILER = 4'd15;

	localparam logic signed [SPILL_W-1:0] SPILL_MAX = 16'sd32767;
	localparam logic [ROLLCNT_W-1:0]      ROLL_MAX  = '1;

	typedef enum logic [1:0] {
		PK_HEADER  = 2'd0,
		PK_TRAILER = 2'd1,
		PK_TRIGGER = 2'd2
	} pend_kind_t;

	typedef struct packed {
		logic [DEV_W-1:0]    device;
		logic [FIFO_W-1:0]   fifo;
		logic [TYPE_W-1:0]   rtype;
		logic [CNT_W-1:0]    counter;
		logic [SPILL_W-1:0]  spill;
		logic [COL_W-1:0]    column;
		logic [PIX_W-1:0]    pixel;
		logic [TDC_W-1:0]    tdc;
		logic [ROLL_W-1:0]   rollover;
		logic [COARSE_W-1:0] coarse;
		logic [FINE_W-1:0]   fine;
		logic                err;
	} record_t;

	function automatic logic [TYPE_W-1:0] kind_type(input pend_kind_t k);
		logic [TYPE_W-1:0] t;
		case (k)
			PK_HEADER:  t = REC_HEADER;
			PK_TRAILER: t = REC_TRAILER;
			default:    t = REC_TRIGGER;
		endcase
		return t;
	endfunction

endpackage

// File: rtl/readout_fifo_word_deframer_unit.sv
// Readout word deframer. Takes one 32-bit readout word per cycle on the slave
// stream (FIFO id in tuser, end-of-buffer in tlast) and emits at most one decoded
// record on the master stream. Throughput is one word per clock; a word sits in the
// input register, then its record is loaded into the result register and offered.
// The input only stalls while both registers are full and the master side is not
// ready. Spill headers, trailers and triggers span two words; the first word of such
// a pair produces no record unless it ends the buffer, which gives an error record.
// The per-FIFO spill counters live in flip-flops that reset to -1 at once, so the
// block takes words right after reset. device_tag is written through cfg_we/cfg_wdata
// and must only change while the block is idle.
module readout_fifo_word_deframer_unit #(
	parameter int NUM_FIFOS = 25
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rfwd_pkg::DEV_W-1:0]     cfg_wdata,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [31:0] data_word
	input  logic [rfwd_pkg::WORD_W-1:0]    s_axis_tdata,
	// [4:0] fifo_id
	input  logic [rfwd_pkg::FIFO_W-1:0]    s_axis_tuser,
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [7:0] device_out, [12:8] fifo_out, [25:13] record_counter,
	// [41:26] spill_number, [45:42] column, [49:46] pixel,
	// [52:50] hit_tdc, [78:53] rollover_value, [94:79] coarse_time,
	// [104:95] fine_time, [111:105] zero
	output logic [rfwd_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// [3:0] record_type, [4] error_flag
	output logic [rfwd_pkg::M_TUSER_W-1:0] m_axis_tuser
);
	import rfwd_pkg::*;

	localparam int IDX_W = (NUM_FIFOS > 1) ? $clog2(NUM_FIFOS) : 1;
	localparam logic [FIFO_W-1:0] TRIG_ID = FIFO_W'(NUM_FIFOS - 1);

	// stage 1: input register
	logic                valid_s1;
	logic [WORD_W-1:0]   word_s1;
	logic [FIFO_W-1:0]   fifo_s1;
	logic                last_s1;
	// stage 2: result register
	logic                valid_s2;
	record_t             rec_s2;

	logic [DEV_W-1:0]    device_tag_q;
	logic                inside_q, inside_d;
	logic [ROLLCNT_W-1:0] roll_q, roll_d;
	logic signed [SPILL_W-1:0] spill_q [NUM_FIFOS];
	logic                pend_valid_q, pend_valid_d;
	pend_kind_t          pend_kind_q, pend_kind_d;
	logic [HEAD_W-1:0]   pend_head_q, pend_head_d;

	logic                s2_free, adv;
	logic signed [SPILL_W-1:0] spill_rd;
	logic                spill_we;
	logic [3:0]          top;
	logic                start_go;
	pend_kind_t          start_kind;
	logic [11:0]         start_cnt;
	logic [39:0]         pair_time;
	logic                emit;
	record_t             rec_d;

	assign s2_free       = !valid_s2 || m_axis_tready;
	assign adv           = valid_s1 && s2_free;
	assign s_axis_tready = !valid_s1 || s2_free;

	assign top       = word_s1[31:28];
	assign spill_rd  = spill_q[fifo_s1[IDX_W-1:0]];
	assign pair_time = {pend_head_q[7:0], word_s1};

	always_comb begin
		inside_d     = inside_q;
		roll_d       = roll_q;
		pend_valid_d = pend_valid_q;
		pend_kind_d  = pend_kind_q;
		pend_head_d  = pend_head_q;
		spill_we     = 1'b0;
		start_go     = 1'b0;
		start_kind   = PK_HEADER;
		emit         = 1'b0;

		rec_d.device   = device_tag_q;
		rec_d.fifo     = fifo_s1;
		rec_d.rtype    = REC_HIT;
		rec_d.counter  = '1;
		rec_d.spill    = spill_rd;
		rec_d.column   = '1;
		rec_d.pixel    = '1;
		rec_d.tdc      = '1;
		rec_d.rollover = '1;
		rec_d.coarse   = '1;
		rec_d.fine     = '1;
		rec_d.err      = 1'b0;

		if (fifo_s1 > TRIG_ID) begin
			pend_valid_d = 1'b0;
		end else if (pend_valid_q) begin
			// second word of a pair completes the pending record
			pend_valid_d   = 1'b0;
			emit           = 1'b1;
			rec_d.rtype    = kind_type(pend_kind_q);
			rec_d.counter  = {1'b0, pend_head_q[19:8]};
			rec_d.rollover = {1'b0, pair_time[39:15]};
			rec_d.coarse   = {1'b0, pair_time[14:0]};
			if (fifo_s1 != TRIG_ID) begin
				if (pend_kind_q == PK_HEADER) begin
					inside_d = 1'b1;
				end else if (pend_kind_q == PK_TRAILER) begin
					inside_d = 1'b0;
					roll_d   = '0;
				end
			end
		end else if (fifo_s1 == TRIG_ID) begin
			case (top)
				TOP_HEADER: begin
					start_go   = 1'b1;
					start_kind = PK_HEADER;
				end
				TOP_TRAILER: begin
					start_go   = 1'b1;
					start_kind = PK_TRAILER;
				end
				TOP_TRIGGER: begin
					start_go   = 1'b1;
					start_kind = PK_TRIGGER;
				end
				default: ;
			endcase
		end else if (!inside_q) begin
			if (top == TOP_HEADER) begin
				start_go   = 1'b1;
				start_kind = PK_HEADER;
			end
		end else if (word_s1 == WORD_KILLED) begin
			emit        = 1'b1;
			rec_d.rtype = REC_TRAILER;
			inside_d    = 1'b0;
			roll_d      = '0;
		end else if (top == TOP_TRAILER) begin
			start_go   = 1'b1;
			start_kind = PK_TRAILER;
		end else if (word_s1 == WORD_ROLLOVER) begin
			if (roll_q != ROLL_MAX) begin
				roll_d = roll_q + ROLLCNT_W'(1);
			end
		end else begin
			emit           = 1'b1;
			rec_d.rtype    = REC_HIT;
			rec_d.column   = {1'b0, word_s1[31:29]};
			rec_d.pixel    = {1'b0, word_s1[28:26]};
			rec_d.tdc      = {1'b0, word_s1[25:24]};
			rec_d.rollover = {1'b0, roll_q};
			rec_d.coarse   = {1'b0, word_s1[23:9]};
			rec_d.fine     = {1'b0, word_s1[8:0]};
		end

		start_cnt = (start_kind == PK_TRIGGER) ? {4'h0, word_s1[23:16]} : word_s1[27:16];

		if (start_go) begin
			if (last_s1) begin
				// first word of a pair ends the buffer: report truncation
				emit          = 1'b1;
				rec_d.rtype   = kind_type(start_kind);
				rec_d.counter = {1'b0, start_cnt};
				rec_d.err     = 1'b1;
			end else begin
				spill_we     = (start_kind == PK_HEADER) && (spill_rd < SPILL_MAX);
				pend_valid_d = 1'b1;
				pend_kind_d  = start_kind;
				pend_head_d  = {start_cnt, word_s1[7:0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_tag_q <= '0;
		end else if (cfg_we) begin
			device_tag_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			word_s1 <= s_axis_tdata;
			fifo_s1 <= s_axis_tuser;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q     <= 1'b0;
			roll_q       <= '0;
			pend_valid_q <= 1'b0;
			pend_kind_q  <= PK_HEADER;
			pend_head_q  <= '0;
			for (int i = 0; i < NUM_FIFOS; i++) begin
				spill_q[i] <= '1;
			end
		end else if (adv) begin
			inside_q     <= inside_d;
			roll_q       <= roll_d;
			pend_valid_q <= pend_valid_d;
			pend_kind_q  <= pend_kind_d;
			pend_head_q  <= pend_head_d;
			if (spill_we) begin
				spill_q[fifo_s1[IDX_W-1:0]] <= spill_rd + SPILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= adv && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			rec_s2 <= rec_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'd0, rec_s2.fine, rec_s2.coarse, rec_s2.rollover, rec_s2.tdc,
		rec_s2.pixel, rec_s2.column, rec_s2.spill, rec_s2.counter, rec_s2.fifo,
		rec_s2.device};
	assign m_axis_tuser  = {rec_s2.err, rec_s2.rtype};

endmodule

// File: rtl/rfwd_checker.sv
module rfwd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [rfwd_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic [rfwd_pkg::M_TUSER_W-1:0] m_axis_tuser
);
	import rfwd_pkg::*;

	// a record waiting on backpressure stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("record dropped under backpressure");

	// truncation errors only come from two-word record types
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[4] |->
			(m_axis_tuser[3:0] == REC_HEADER || m_axis_tuser[3:0] == REC_TRAILER ||
			 m_axis_tuser[3:0] == REC_TRIGGER))
		else $error("error flag on a non-pair record");

	// truncated records carry no time
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[4] |->
			(m_axis_tdata[94:53] == '1 && m_axis_tdata[104:95] == '1))
		else $error("truncated record carries time fields");

	// hits carry no counter, no error, and pad bits stay clear
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[3:0] == REC_HIT |->
			(m_axis_tdata[25:13] == '1 && !m_axis_tuser[4] && m_axis_tdata[111:105] == '0))
		else $error("malformed hit record");

endmodule

bind readout_fifo_word_deframer_unit rfwd_checker u_rfwd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// File: tb/deframer_record_checker.sv
module deframer_record_checker
	import rfwd_pkg::*;
#(
	parameter int NUM_FIFOS = 25
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [DEV_W-1:0]      cfg_wdata,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [WORD_W-1:0]     s_axis_tdata,
	input  logic [FIFO_W-1:0]     s_axis_tuser,
	input  logic                  s_axis_tlast,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [M_TDATA_W-1:0]  m_axis_tdata,
	input  logic [M_TUSER_W-1:0]  m_axis_tuser,
	output int                    fail_count,
	output int                    records_due
);

	localparam logic [FIFO_W-1:0] TRIG = FIFO_W'(NUM_FIFOS - 1);

	// decoder state, mirrored from the block's behavior
	logic [DEV_W-1:0]            tag;
	bit                          spill_open;
	logic [ROLLCNT_W-1:0]        roll_cnt;
	logic signed [SPILL_W-1:0]   spill_cnt [NUM_FIFOS];
	bit                          pair_open;
	pend_kind_t                  pair_kind;
	logic [HEAD_W-1:0]           pair_head;

	record_t due_q[$];
	int fails = 0;

	assign fail_count = fails;

	function automatic logic [TYPE_W-1:0] rec_type_for(input pend_kind_t k);
		logic [TYPE_W-1:0] t;
		case (k)
			PK_HEADER:  t = REC_HEADER;
			PK_TRAILER: t = REC_TRAILER;
			default:    t = REC_TRIGGER;
		endcase
		return t;
	endfunction

	task automatic post_record(input logic [FIFO_W-1:0] f, input logic [TYPE_W-1:0] rtype,
			input logic [CNT_W-1:0] cnt, input logic [SPILL_W-1:0] spill,
			input logic [COL_W-1:0] col, input logic [PIX_W-1:0] pix,
			input logic [TDC_W-1:0] tdc, input logic [ROLL_W-1:0] roll,
			input logic [COARSE_W-1:0] coarse, input logic [FINE_W-1:0] fine,
			input logic err);
		record_t r;
		r.device   = tag;
		r.fifo     = f;
		r.rtype    = rtype;
		r.counter  = cnt;
		r.spill    = spill;
		r.column   = col;
		r.pixel    = pix;
		r.tdc      = tdc;
		r.rollover = roll;
		r.coarse   = coarse;
		r.fine     = fine;
		r.err      = err;
		due_q.push_back(r);
	endtask

	task automatic open_pair(input logic [WORD_W-1:0] w, input logic [FIFO_W-1:0] f,
			input pend_kind_t k, input logic last);
		logic [11:0] cnt;
		cnt = (k == PK_TRIGGER) ? {4'h0, w[23:16]} : w[27:16];
		if (last) begin
			// truncated pair: error record, nothing else moves
			post_record(f, rec_type_for(k), {1'b0, cnt}, spill_cnt[f],
				'1, '1, '1, '1, '1, '1, 1'b1);
		end else begin
			if (k == PK_HEADER && spill_cnt[f] < SPILL_MAX)
				spill_cnt[f] = spill_cnt[f] + SPILL_W'(1);
			pair_open = 1'b1;
			pair_kind = k;
			pair_head = {cnt, w[7:0]};
		end
	endtask

	task automatic decode_word(input logic [WORD_W-1:0] w, input logic [FIFO_W-1:0] f,
			input logic last);
		logic [39:0] stamp;
		logic [3:0]  top;
		top = w[31:28];
		if (f > TRIG) begin
			pair_open = 1'b0;
		end else if (pair_open) begin
			// second word of a pair, whatever its buffer end
			stamp = {pair_head[7:0], w};
			pair_open = 1'b0;
			if (f < TRIG) begin
				if (pair_kind == PK_HEADER) begin
					spill_open = 1'b1;
				end else if (pair_kind == PK_TRAILER) begin
					spill_open = 1'b0;
					roll_cnt = '0;
				end
			end
			post_record(f, rec_type_for(pair_kind), {1'b0, pair_head[19:8]}, spill_cnt[f],
				'1, '1, '1, {1'b0, stamp[39:15]}, {1'b0, stamp[14:0]}, '1, 1'b0);
		end else if (f == TRIG) begin
			case (top)
				TOP_HEADER:  open_pair(w, f, PK_HEADER, last);
				TOP_TRAILER: open_pair(w, f, PK_TRAILER, last);
				TOP_TRIGGER: open_pair(w, f, PK_TRIGGER, last);
				default: ;
			endcase
		end else if (!spill_open) begin
			if (top == TOP_HEADER)
				open_pair(w, f, PK_HEADER, last);
		end else if (w == WORD_KILLED) begin
			post_record(f, REC_TRAILER, '1, spill_cnt[f], '1, '1, '1, '1, '1, '1, 1'b0);
			spill_open = 1'b0;
			roll_cnt = '0;
		end else if (top == TOP_TRAILER) begin
			open_pair(w, f, PK_TRAILER, last);
		end else if (w == WORD_ROLLOVER) begin
			if (roll_cnt != ROLL_MAX)
				roll_cnt = roll_cnt + ROLLCNT_W'(1);
		end else begin
			post_record(f, REC_HIT, '1, spill_cnt[f], {1'b0, w[31:29]}, {1'b0, w[28:26]},
				{1'b0, w[25:24]}, {1'b0, roll_cnt}, {1'b0, w[23:9]}, {1'b0, w[8:0]}, 1'b0);
		end
	endtask

	task automatic cmp_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			fails++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		record_t want;
		record_t got;
		logic [6:0] pad;
		if (!arst_n) begin
			tag = '0;
			spill_open = 1'b0;
			roll_cnt = '0;
			for (int i = 0; i < NUM_FIFOS; i++)
				spill_cnt[i] = '1;
			pair_open = 1'b0;
			pair_kind = PK_HEADER;
			pair_head = '0;
			due_q.delete();
			records_due <= 0;
		end else begin
			if (cfg_we)
				tag = cfg_wdata;
			if (m_axis_tvalid && m_axis_tready) begin
				got.device   = m_axis_tdata[7:0];
				got.fifo     = m_axis_tdata[12:8];
				got.counter  = m_axis_tdata[25:13];
				got.spill    = m_axis_tdata[41:26];
				got.column   = m_axis_tdata[45:42];
				got.pixel    = m_axis_tdata[49:46];
				got.tdc      = m_axis_tdata[52:50];
				got.rollover = m_axis_tdata[78:53];
				got.coarse   = m_axis_tdata[94:79];
				got.fine     = m_axis_tdata[104:95];
				pad          = m_axis_tdata[111:105];
				got.rtype    = m_axis_tuser[3:0];
				got.err      = m_axis_tuser[4];
				if (due_q.size() == 0) begin
					fails++;
					$display("%0t: record with none due, expected nothing, actual %h %h",
						$time, m_axis_tuser, m_axis_tdata);
				end else begin
					want = due_q.pop_front();
					cmp_field("device_out", 32'(want.device), 32'(got.device));
					cmp_field("fifo_out", 32'(want.fifo), 32'(got.fifo));
					cmp_field("record_type", 32'(want.rtype), 32'(got.rtype));
					cmp_field("record_counter", 32'(want.counter), 32'(got.counter));
					cmp_field("spill_number", 32'(want.spill), 32'(got.spill));
					cmp_field("column", 32'(want.column), 32'(got.column));
					cmp_field("pixel", 32'(want.pixel), 32'(got.pixel));
					cmp_field("hit_tdc", 32'(want.tdc), 32'(got.tdc));
					cmp_field("rollover_value", 32'(want.rollover), 32'(got.rollover));
					cmp_field("coarse_time", 32'(want.coarse), 32'(got.coarse));
					cmp_field("fine_time", 32'(want.fine), 32'(got.fine));
					cmp_field("error_flag", 32'(want.err), 32'(got.err));
					cmp_field("tdata padding", '0, 32'(pad));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				decode_word(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			records_due <= due_q.size();
		end
	end

endmodule

// File: tb/readout_fifo_word_deframer_unit_tb.sv
module readout_fifo_word_deframer_unit_tb;
	import rfwd_pkg::*;

	localparam int NUM_FIFOS = 25;
	localparam int TRIG_FIFO = NUM_FIFOS - 1;
	localparam int PHASE_WORDS = 90;
	localparam int LONG_HOLD = 300;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [DEV_W-1:0]      cfg_wdata;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [WORD_W-1:0]     s_axis_tdata;
	logic [FIFO_W-1:0]     s_axis_tuser;
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic [M_TUSER_W-1:0]  m_axis_tuser;

	int fail_count;
	int records_due;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req_cnt = 0;
	int hold_ack_cnt = 0;
	int hold_left = 0;
	int words_counted = 0;

	readout_fifo_word_deframer_unit #(.NUM_FIFOS(NUM_FIFOS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	deframer_record_checker #(.NUM_FIFOS(NUM_FIFOS)) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.fail_count(fail_count),
		.records_due(records_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("FAIL readout_fifo_word_deframer_unit");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_req_cnt != hold_ack_cnt) begin
			hold_ack_cnt++;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic put_word(input logic [WORD_W-1:0] w, input int f, input int last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= w;
		s_axis_tuser  <= FIFO_W'(f);
		s_axis_tlast  <= last[0];
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (f <= TRIG_FIFO)
			words_counted++;
	endtask

	// wait until every record has come out, then let the pipe settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (records_due != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_tag(input logic [DEV_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [WORD_W-1:0] prefixed_word(input logic [3:0] top);
		logic [WORD_W-1:0] r;
		r = $urandom;
		r[31:28] = top;
		return r;
	endfunction

	// random hit: never a trailer prefix or a special word
	function automatic logic [WORD_W-1:0] hit_word();
		logic [WORD_W-1:0] r;
		r = $urandom;
		if (r[31:28] == TOP_TRAILER)
			r[28] = 1'b0;
		if (r == WORD_KILLED || r == WORD_ROLLOVER)
			r[0] = ~r[0];
		return r;
	endfunction

	function automatic logic [3:0] pair_top();
		logic [3:0] t;
		case ($urandom_range(2))
			0:       t = TOP_HEADER;
			1:       t = TOP_TRAILER;
			default: t = TOP_TRIGGER;
		endcase
		return t;
	endfunction

	task automatic run_spill();
		int f;
		int n;
		f = $urandom_range(TRIG_FIFO - 1);
		n = $urandom_range(1, 10);
		put_word(prefixed_word(TOP_HEADER), f, 0);
		put_word($urandom, f, $urandom_range(1));
		repeat (n) begin
			case ($urandom_range(19))
				0, 1, 2: put_word(WORD_ROLLOVER, f, $urandom_range(1));
				3:       put_word($urandom, $urandom_range(31), $urandom_range(1));
				4, 5:    put_word(hit_word(), $urandom_range(TRIG_FIFO - 1), $urandom_range(1));
				default: put_word(hit_word(), f, $urandom_range(1));
			endcase
		end
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: begin
				put_word(prefixed_word(TOP_TRAILER), f, 0);
				put_word($urandom, f, $urandom_range(1));
			end
			6, 7, 8: put_word(WORD_KILLED, f, $urandom_range(1));
			default: ;
		endcase
	endtask

	task automatic run_trigger_pair();
		put_word(prefixed_word(pair_top()), TRIG_FIFO, 0);
		// now and then the second word arrives on a data FIFO
		if ($urandom_range(4) == 0)
			put_word($urandom, $urandom_range(TRIG_FIFO - 1), $urandom_range(1));
		else
			put_word($urandom, TRIG_FIFO, $urandom_range(1));
	endtask

	task automatic run_broken();
		case ($urandom_range(3))
			0: put_word(prefixed_word(TOP_HEADER), $urandom_range(TRIG_FIFO - 1), 1);
			1: put_word(prefixed_word(pair_top()), TRIG_FIFO, 1);
			2: begin
				put_word(prefixed_word(pair_top()), $urandom_range(TRIG_FIFO), 0);
				put_word($urandom, $urandom_range(TRIG_FIFO + 1, 31), $urandom_range(1));
			end
			default: put_word(prefixed_word(TOP_TRAILER), $urandom_range(TRIG_FIFO - 1), 1);
		endcase
	endtask

	task automatic run_phase(input int idle, input int stall, input int t,
			input bit long_hold);
		int start;
		drain();
		set_tag(DEV_W'(t));
		send_idle_pct = idle;
		recv_stall_pct <= stall;
		if (long_hold)
			hold_req_cnt <= hold_req_cnt + 1;
		start = words_counted;
		while (words_counted - start < PHASE_WORDS) begin
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5, 6, 7, 8: run_spill();
				9, 10, 11, 12, 13:         run_trigger_pair();
				14, 15, 16:                run_broken();
				default: put_word($urandom, $urandom_range(31), $urandom_range(1));
			endcase
		end
	endtask

	initial begin : stimulus
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		s_axis_tlast  <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_tag(8'hFF);

		// data word before any header: dropped
		put_word(32'h1234_5678, 0, 0);
		// header cut by buffer end: error record, spill count untouched
		put_word({TOP_HEADER, 28'hABC_0011}, 3, 1);
		put_word({TOP_HEADER, 28'hFFF_00FF}, 3, 0);
		put_word(32'hFFFF_FFFF, 3, 1);
		put_word(32'h0000_0000, 3, 0);
		put_word(32'hEFFF_FFFF, 23, 1);
		put_word(32'hDFFF_FFFF, 3, 0);
		put_word(WORD_ROLLOVER, 3, 0);
		put_word(WORD_ROLLOVER, 7, 0);
		put_word(32'h1234_5678, 0, 0);
		// trailer cut by buffer end, then a full trailer
		put_word({TOP_TRAILER, 28'h000_0000}, 3, 1);
		put_word({TOP_TRAILER, 28'h123_4567}, 3, 0);
		put_word(32'h89AB_CDEF, 3, 0);
		put_word(WORD_ROLLOVER, 3, 0);
		// pending header dropped by an ignored FIFO
		put_word({TOP_HEADER, 28'h002_0001}, 5, 0);
		put_word(32'h0000_0000, 31, 0);
		// header completed on the trigger FIFO: no spill entry
		put_word({TOP_HEADER, 28'h003_0000}, 5, 0);
		put_word(32'h1111_1111, TRIG_FIFO, 0);
		put_word(32'h5555_5555, 5, 0);
		put_word({TOP_TRIGGER, 28'hFAB_00C3}, TRIG_FIFO, 0);
		put_word(32'hFFFF_FFFF, TRIG_FIFO, 1);
		put_word({TOP_TRIGGER, 28'h000_0000}, TRIG_FIFO, 1);
		put_word(32'h1234_5678, TRIG_FIFO, 0);
		// header into spill on fifo 0, then the killed-FIFO word
		put_word({TOP_HEADER, 28'h00F_0080}, 0, 0);
		put_word(32'h0000_7FFF, 0, 0);
		put_word(WORD_KILLED, 0, 0);
		put_word(32'hA5A5_A5A5, TRIG_FIFO + 1, 1);
		drain();

		run_phase(0, 0, $urandom_range(255), 1'b0);
		run_phase(78, 0, 1, 1'b0);
		run_phase(0, 78, 255, 1'b1);
		run_phase(24, 24, 128, 1'b0);
		drain();

		if (fail_count == 0)
			$display("PASS readout_fifo_word_deframer_unit");
		else
			$display("FAIL readout_fifo_word_deframer_unit");
		$finish;
	end

endmodule
